// ===== src/full_linear_convolution_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Full linear convolution unit - assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef FULL_LINEAR_CONVOLUTION_UNIT_DEFINES_SVH
`define FULL_LINEAR_CONVOLUTION_UNIT_DEFINES_SVH

// same-cycle implication
`define FLC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flc assertion failed");

// next-cycle implication
`define FLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flc assertion failed");

`endif

// ===== src/flc_pkg.sv =====
// ----------------------------------------------------------------------------
// flc_pkg
// Widths, register codes, types and reset values for the convolution unit.
// ----------------------------------------------------------------------------
`default_nettype none

package flc_pkg;

   localparam int MaxTapsDefault = 7;
   localparam int SampleWidth    = 16;
   localparam int ValueWidth     = 35;
   localparam int ProdWidth      = 2 * SampleWidth;
   localparam int CountWidth     = 3;
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 16;
   localparam int NumCsrTaps     = 7;
   localparam int ReqDataWidth   = 16;
   localparam int RspDataWidth   = 40;

   localparam logic [CsrIndexWidth-1:0] CsrTapCount = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrTapBase  = 3'd1;

   localparam logic [CountWidth-1:0] TapCountReset = 3'd3;
   localparam logic [CountWidth-1:0] OneTap        = 3'd1;

   typedef struct packed {
      logic                         last;
      logic signed [ValueWidth-1:0] acc;
   } flc_sum_type;

   typedef struct packed {
      logic flushing;
      logic hist_clear;
   } flc_feed_stat_type;

   function automatic logic signed [SampleWidth-1:0] tap_reset_value(input int idx);
      logic signed [SampleWidth-1:0] v;
      case (idx)
         0:       v = 16'sd8192;
         1:       v = 16'sd16384;
         2:       v = 16'sd8192;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== src/full_linear_convolution_unit.sv =====
// ----------------------------------------------------------------------------
// full_linear_convolution_unit
// Streaming FIR filter giving the full linear convolution of each signal
// with the configured kernel; a tlast request adds k_eff-1 flush results (tap_count clamped to 1..MaxK).
//
//   channel  dir  fields
//   req_     in   tdata: sample[15:0]; tlast: end_of_signal
//   rsp_     out  tdata: value[34:0], zero pad[39:35]; tlast: last_of_run
//   csr_     in   index 0 tap_count, 1..7 tap_0..tap_6
//
// One request per cycle unless stalled or flushing; the feeder and one MAC cell per tap are each registered.
// After a tlast request req_tready stays low while its flush results are issued.
// Reset is synchronous; taps and tap_count return to their default kernel.
// rsp_tready low stalls the chain from the back; empty stages still fill.
// ----------------------------------------------------------------------------
`default_nettype none
`include "full_linear_convolution_unit_defines.svh"

module full_linear_convolution_unit #(
   parameter int MAX_TAPS = flc_pkg::MaxTapsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [flc_pkg::ReqDataWidth-1:0]     req_tdata,  // sample[15:0]
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [flc_pkg::RspDataWidth-1:0]     rsp_tdata,  // value[34:0], pad
   output logic                                 rsp_tlast,
   input  logic                                 csr_we,
   input  logic [flc_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [flc_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import flc_pkg::*;

   localparam logic [CountWidth-1:0] MaxK =
      CountWidth'((MAX_TAPS < NumCsrTaps) ? MAX_TAPS : NumCsrTaps);

   logic [CountWidth-1:0]                        tap_count_ff, tap_count_in;
   logic signed [SampleWidth-1:0]                taps_ff [MAX_TAPS];
   logic signed [SampleWidth-1:0]                taps_in [MAX_TAPS];
   logic signed [SampleWidth-1:0]                tap_eff [MAX_TAPS];
   logic [CountWidth-1:0]                        k_eff;

   logic [MAX_TAPS:0]                            valid;
   logic [MAX_TAPS:0]                            ready;
   logic [MAX_TAPS-1:0][SampleWidth-1:0]         win [MAX_TAPS];
   flc_sum_type                                  sum [MAX_TAPS+1];
   logic                                         feed_last;
   flc_feed_stat_type                            feed_stat;

   // configuration
   always_comb begin
      tap_count_in = tap_count_ff;
      taps_in      = taps_ff;
      if (csr_we) begin
         if (csr_index == CsrTapCount) begin
            tap_count_in = csr_wdata[CountWidth-1:0];
         end
         for (int j = 0; j < MAX_TAPS; j++) begin
            if (j < NumCsrTaps &&
                csr_index == CsrIndexWidth'(int'(CsrTapBase) + j)) begin
               taps_in[j] = signed'(csr_wdata[SampleWidth-1:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TapCountReset;
         for (int j = 0; j < MAX_TAPS; j++) begin
            taps_ff[j] <= tap_reset_value(j);
         end
      end else begin
         tap_count_ff <= tap_count_in;
         taps_ff      <= taps_in;
      end
   end

   always_comb begin
      if (tap_count_ff == '0) begin
         k_eff = OneTap;
      end else if (tap_count_ff > MaxK) begin
         k_eff = MaxK;
      end else begin
         k_eff = tap_count_ff;
      end
      for (int j = 0; j < MAX_TAPS; j++) begin
         tap_eff[j] = (j < int'(k_eff)) ? taps_ff[j] : '0;
      end
   end

   flc_feeder #(
      .MAX_TAPS (MAX_TAPS)
   ) u_feeder (
      .clock     (clock),
      .reset     (reset),
      .tap_num   (k_eff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sample (signed'(req_tdata[SampleWidth-1:0])),
      .in_last   (req_tlast),
      .out_valid (valid[0]),
      .out_ready (ready[0]),
      .out_win   (win[0]),
      .out_last  (feed_last),
      .stat      (feed_stat)
   );

   assign sum[0].last = feed_last;
   assign sum[0].acc  = '0;

   for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
      if (g < MAX_TAPS - 1) begin : g_mid
         flc_mac_cell #(
            .MAX_TAPS (MAX_TAPS),
            .STAGE    (g)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .tap       (tap_eff[g]),
            .in_valid  (valid[g]),
            .in_ready  (ready[g]),
            .in_win    (win[g]),
            .in_sum    (sum[g]),
            .out_valid (valid[g+1]),
            .out_ready (ready[g+1]),
            .out_win   (win[g+1]),
            .out_sum   (sum[g+1])
         );
      end else begin : g_end
         flc_mac_cell #(
            .MAX_TAPS (MAX_TAPS),
            .STAGE    (g)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .tap       (tap_eff[g]),
            .in_valid  (valid[g]),
            .in_ready  (ready[g]),
            .in_win    (win[g]),
            .in_sum    (sum[g]),
            .out_valid (valid[g+1]),
            .out_ready (ready[g+1]),
            .out_win   (),
            .out_sum   (sum[g+1])
         );
      end
   end

   assign ready[MAX_TAPS] = rsp_tready;
   assign rsp_tvalid      = valid[MAX_TAPS];
   assign rsp_tdata       = {{(RspDataWidth - ValueWidth){1'b0}}, sum[MAX_TAPS].acc};
   assign rsp_tlast       = sum[MAX_TAPS].last;

   `FLC_ASSERT_SAME(a_flush_blocks_req, clock, reset, feed_stat.flushing, !req_tready)
   `FLC_ASSERT_NEXT(a_end_starts_flush, clock, reset, req_tvalid && req_tready && req_tlast && (k_eff != OneTap), feed_stat.flushing && !req_tready)
   `FLC_ASSERT_NEXT(a_single_tap_end_clears, clock, reset, req_tvalid && req_tready && req_tlast && (k_eff == OneTap), feed_stat.hist_clear && !feed_stat.flushing)

endmodule

`default_nettype wire

// ===== src/flc_feeder.sv =====
// ----------------------------------------------------------------------------
// flc_feeder
// Delay line and flush sequencer: builds one sample window per request or
// per flush step and hands it to the first MAC cell.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_feeder #(
   parameter int MAX_TAPS = flc_pkg::MaxTapsDefault
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic [flc_pkg::CountWidth-1:0]                 tap_num,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic signed [flc_pkg::SampleWidth-1:0]         in_sample,
   input  logic                                           in_last,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output logic [MAX_TAPS-1:0][flc_pkg::SampleWidth-1:0]  out_win,
   output logic                                           out_last,
   output flc_pkg::flc_feed_stat_type                     stat
);
   import flc_pkg::*;

   logic                                    valid_ff, valid_in;
   logic                                    last_ff, last_in;
   logic                                    flush_ff, flush_in;
   logic                                    clear_ff, clear_in;
   logic [CountWidth-1:0]                   cnt_ff, cnt_in;
   logic [MAX_TAPS-1:0][SampleWidth-1:0]    win_ff, win_in;

   logic                    load;
   logic                    take;
   logic                    step;
   logic                    ends;
   logic signed [SampleWidth-1:0] x;

   assign load     = !valid_ff || out_ready;
   assign in_ready = load && !flush_ff;
   assign take     = in_valid && in_ready;
   assign step     = flush_ff && load;
   assign x        = flush_ff ? '0 : in_sample;
   assign ends     = step ? (cnt_ff == CountWidth'(tap_num - OneTap))
                          : (in_last && tap_num == OneTap);

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      flush_in = flush_ff;
      clear_in = clear_ff;
      cnt_in   = cnt_ff;
      win_in   = win_ff;
      if (take || step) begin
         valid_in  = 1'b1;
         last_in   = ends;
         clear_in  = ends;
         win_in[0] = x;
         for (int j = 1; j < MAX_TAPS; j++) begin
            win_in[j] = clear_ff ? '0 : win_ff[j-1];
         end
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
      if (take && in_last && tap_num != OneTap) begin
         flush_in = 1'b1;
         cnt_in   = OneTap;
      end else if (step) begin
         flush_in = !ends;
         cnt_in   = cnt_ff + OneTap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flush_ff <= 1'b0;
         clear_ff <= 1'b1;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         flush_ff <= flush_in;
         clear_ff <= clear_in;
         cnt_ff   <= cnt_in;
      end
      last_ff <= last_in;
      win_ff  <= win_in;
   end

   assign out_valid       = valid_ff;
   assign out_win         = win_ff;
   assign out_last        = last_ff;
   assign stat.flushing   = flush_ff;
   assign stat.hist_clear = clear_ff;

endmodule

`default_nettype wire

// ===== src/flc_mac_cell.sv =====
// ----------------------------------------------------------------------------
// flc_mac_cell
// One tap of the systolic chain: multiplies its coefficient with its window
// slot, adds to the running sum and passes window and sum to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module flc_mac_cell #(
   parameter int MAX_TAPS = flc_pkg::MaxTapsDefault,
   parameter int STAGE    = 0
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic signed [flc_pkg::SampleWidth-1:0]         tap,
   input  logic                                           in_valid,
   output logic                                           in_ready,
   input  logic [MAX_TAPS-1:0][flc_pkg::SampleWidth-1:0]  in_win,
   input  flc_pkg::flc_sum_type                           in_sum,
   output logic                                           out_valid,
   input  logic                                           out_ready,
   output logic [MAX_TAPS-1:0][flc_pkg::SampleWidth-1:0]  out_win,
   output flc_pkg::flc_sum_type                           out_sum
);
   import flc_pkg::*;

   logic                                  valid_ff, valid_in;
   logic [MAX_TAPS-1:0][SampleWidth-1:0]  win_ff, win_in;
   flc_sum_type                           sum_ff, sum_in;
   logic signed [ProdWidth-1:0]           prod;

   assign in_ready = !valid_ff || out_ready;
   assign prod     = tap * signed'(in_win[STAGE]);

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      win_in   = win_ff;
      sum_in   = sum_ff;
      if (in_valid && in_ready) begin
         win_in      = in_win;
         sum_in.last = in_sum.last;
         sum_in.acc  = in_sum.acc
                     + {{(ValueWidth - ProdWidth){prod[ProdWidth-1]}}, prod};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      win_ff <= win_in;
      sum_ff <= sum_in;
   end

   assign out_valid = valid_ff;
   assign out_win   = win_ff;
   assign out_sum   = sum_ff;

endmodule

`default_nettype wire
